// File: hdl/j1939_frame_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// J1939 frame classifier assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef J1939_FRAME_CLASSIFIER_CORE_MACROS_SVH
`define J1939_FRAME_CLASSIFIER_CORE_MACROS_SVH

// Property checked on every rising clk edge outside of reset
`define J1939FC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication
`define J1939FC_ASSERT_IMPL(label, pre, post, msg) \
	`J1939FC_ASSERT(label, (pre) |-> (post), msg)

// Next-cycle implication
`define J1939FC_ASSERT_NEXT(label, pre, post, msg) \
	`J1939FC_ASSERT(label, (pre) |=> (post), msg)

`endif

// File: hdl/j1939fc_pkg.sv
// ----------------------------------------------------------------------------
// J1939 frame classifier package
// Shared types, codes and constants of the classifier pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package j1939fc_pkg;

	// Port widths
	localparam int IdWidth      = 29;
	localparam int InDataWidth  = 32;
	localparam int OutDataWidth = 40;
	localparam int CfgWidth     = 18;
	localparam int CfgIdxWidth  = 3;
	localparam int PgnWidth     = 18;

	// Message class codes, in rule priority order
	typedef enum logic [4:0] {
		CLS_REQ              = 5'd0,
		CLS_DM14             = 5'd1,
		CLS_ACK              = 5'd2,
		CLS_DM15             = 5'd3,
		CLS_DM16             = 5'd4,
		CLS_TP_CM            = 5'd5,
		CLS_TP_DT            = 5'd6,
		CLS_PROP_A           = 5'd7,
		CLS_PROP_B           = 5'd8,
		CLS_ADDR_CLAIMED     = 5'd9,
		CLS_ADDR_NOT_CLAIMED = 5'd10,
		CLS_DM1              = 5'd11,
		CLS_DM2              = 5'd12,
		CLS_SW_ID            = 5'd13,
		CLS_ECU_ID           = 5'd14,
		CLS_COMP_ID          = 5'd15,
		CLS_AUX_FLOW         = 5'd16,
		CLS_GP_FLOW          = 5'd17,
		CLS_AUX_POS          = 5'd18,
		CLS_AUX_CMD          = 5'd19,
		CLS_GP_CMD           = 5'd20,
		CLS_ADDR_DELETE      = 5'd21,
		CLS_UNKNOWN          = 5'd22
	} cls_e;

	// One rule per class below unknown
	localparam int NumRules = 22;
	typedef logic [NumRules-1:0] rule_hits_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_OWN_ADDRESS  = 3'd0,
		CFG_PROP_B_LOW   = 3'd1,
		CFG_PROP_B_HIGH  = 3'd2,
		CFG_PROP_B2_LOW  = 3'd3,
		CFG_PROP_B2_HIGH = 3'd4
	} cfg_idx_e;

	// Register reset values
	localparam logic [7:0]          OwnAddressRst = 8'd128;
	localparam logic [PgnWidth-1:0] PropBLowRst   = 18'h0FF00;
	localparam logic [PgnWidth-1:0] PropBHighRst  = 18'h0FFFF;
	localparam logic [PgnWidth-1:0] PropB2LowRst  = 18'h1FF00;
	localparam logic [PgnWidth-1:0] PropB2HighRst = 18'h1FFFF;

	// Top field codes (priority, EDP, DP)
	localparam logic [4:0] TopP6 = 5'h18;
	localparam logic [4:0] TopP7 = 5'h1C;
	localparam logic [4:0] TopP5 = 5'h14;
	localparam logic [4:0] TopP3 = 5'h0C;
	localparam logic [4:0] TopP0 = 5'h00;

	// PDU format codes
	localparam logic [7:0] PfPdu2Min   = 8'd240;
	localparam logic [7:0] PfRequest   = 8'hEA;
	localparam logic [7:0] PfDm14      = 8'hD9;
	localparam logic [7:0] PfAck       = 8'hE8;
	localparam logic [7:0] PfDm15      = 8'hD8;
	localparam logic [7:0] PfDm16      = 8'hD7;
	localparam logic [7:0] PfTpCm      = 8'hEC;
	localparam logic [7:0] PfTpDt      = 8'hEB;
	localparam logic [7:0] PfPropA     = 8'hEF;
	localparam logic [7:0] PfAddrClaim = 8'hEE;
	localparam logic [7:0] PfFe        = 8'hFE;
	localparam logic [7:0] PfFd        = 8'hFD;
	localparam logic [7:0] PfFf        = 8'hFF;
	localparam logic [7:0] PfGpFlow    = 8'hC6;
	localparam logic [7:0] PfGpCmd     = 8'hC4;
	localparam logic [7:0] PfAddrDel   = 8'h02;

	// Destination / PDU specific codes
	localparam logic [7:0] DaGlobal  = 8'hFF;
	localparam logic [7:0] DaPropA   = 8'h23;
	localparam logic [7:0] DaDm1     = 8'hCA;
	localparam logic [7:0] DaDm2     = 8'hCB;
	localparam logic [7:0] DaSwId    = 8'hDA;
	localparam logic [7:0] DaEcuId   = 8'hC5;
	localparam logic [7:0] DaCompId  = 8'hEB;
	localparam logic [3:0] DaAuxFlow = 4'h1;
	localparam logic [3:0] DaAuxPos  = 4'h2;
	localparam logic [3:0] DaAuxCmd  = 4'h3;
	localparam logic [7:0] SaNull    = 8'hFE;

	// Configuration as seen by the rule stage
	typedef struct packed {
		logic [7:0]          own_address;
		logic [PgnWidth-1:0] prop_b_low;
		logic [PgnWidth-1:0] prop_b_high;
		logic [PgnWidth-1:0] prop_b2_low;
		logic [PgnWidth-1:0] prop_b2_high;
	} cfg_t;

	// Stage 1: split identifier
	typedef struct packed {
		logic [4:0]          top;
		logic [7:0]          pf;
		logic [7:0]          da;
		logic [7:0]          sa;
		logic [PgnWidth-1:0] pgn;
	} fields_t;

	// Stage 2: rule hits
	typedef struct packed {
		rule_hits_t          hits;
		logic [3:0]          da_low;
		logic [7:0]          sa;
		logic [PgnWidth-1:0] pgn;
	} match_t;

	// Stage 3: result item
	typedef struct packed {
		logic [3:0]          valve_number;
		logic [7:0]          src_addr;
		logic [PgnWidth-1:0] pgn;
		cls_e                msg_class;
	} result_t;

endpackage

// File: hdl/j1939_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// J1939 frame classifier core
// Classifies received 29-bit identifiers into J1939 message classes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                   Payload
//  s_axis    in   s_axis_tvalid/tready        can_id
//  m_axis    out  m_axis_tvalid/tready        msg_class, pgn, src_addr,
//                                             valve_number
//  cfg       in   cfg_wr_en (no wait)         cfg_index, cfg_data
//
//  Three register stages (decode, rule match, priority pick): an item passes
//  through the decode, rule match and priority pick registers in that order;
//  one item per cycle sustained while m_axis_tready keeps the output free.
//  Each stage holds while the stage after it is full and stalled; nothing
//  is dropped or repeated. Reset clears stage valids and loads register
//  defaults. Configuration is read by the rule stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module j1939_frame_classifier_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input items
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [j1939fc_pkg::InDataWidth-1:0]    s_axis_tdata,  // [28:0] can_id
	// Result items
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [4:0] msg_class, [22:5] pgn, [30:23] src_addr, [34:31] valve_number
	output logic [j1939fc_pkg::OutDataWidth-1:0]   m_axis_tdata,
	// Configuration writes
	input  logic                                   cfg_wr_en,
	input  logic [j1939fc_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  logic [j1939fc_pkg::CfgWidth-1:0]       cfg_data
);

	j1939fc_pkg::cfg_t    cfg_q;
	j1939fc_pkg::fields_t fields;
	j1939fc_pkg::match_t  match;
	j1939fc_pkg::result_t result;
	logic dec_valid, match_ready, match_valid, prio_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address  <= j1939fc_pkg::OwnAddressRst;
			cfg_q.prop_b_low   <= j1939fc_pkg::PropBLowRst;
			cfg_q.prop_b_high  <= j1939fc_pkg::PropBHighRst;
			cfg_q.prop_b2_low  <= j1939fc_pkg::PropB2LowRst;
			cfg_q.prop_b2_high <= j1939fc_pkg::PropB2HighRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				j1939fc_pkg::CFG_OWN_ADDRESS:  cfg_q.own_address  <= cfg_data[7:0];
				j1939fc_pkg::CFG_PROP_B_LOW:   cfg_q.prop_b_low   <= cfg_data;
				j1939fc_pkg::CFG_PROP_B_HIGH:  cfg_q.prop_b_high  <= cfg_data;
				j1939fc_pkg::CFG_PROP_B2_LOW:  cfg_q.prop_b2_low  <= cfg_data;
				j1939fc_pkg::CFG_PROP_B2_HIGH: cfg_q.prop_b2_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: field split
	j1939fc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.can_id    (s_axis_tdata[j1939fc_pkg::IdWidth-1:0]),
		.out_valid (dec_valid),
		.out_ready (match_ready),
		.fields    (fields)
	);

	// Stage 2: rule evaluation
	j1939fc_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (dec_valid),
		.in_ready  (match_ready),
		.fields    (fields),
		.out_valid (match_valid),
		.out_ready (prio_ready),
		.match     (match)
	);

	// Stage 3: priority pick and output register
	j1939fc_prio u_prio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (match_valid),
		.in_ready  (prio_ready),
		.match     (match),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {5'b0, result.valve_number, result.src_addr,
		result.pgn, result.msg_class};

endmodule

// File: hdl/j1939fc_decode.sv
// ----------------------------------------------------------------------------
// J1939 classifier decode stage
// Splits the identifier into fields and derives the PGN.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module j1939fc_decode (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [j1939fc_pkg::IdWidth-1:0]    can_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output j1939fc_pkg::fields_t               fields
);

	logic                 valid_s1;
	j1939fc_pkg::fields_t data_s1;
	j1939fc_pkg::fields_t next_fields;

	// Field split; PS is kept only for PDU2 formats
	always_comb begin
		next_fields.top = can_id[28:24];
		next_fields.pf  = can_id[23:16];
		next_fields.da  = can_id[15:8];
		next_fields.sa  = can_id[7:0];
		next_fields.pgn = {can_id[25:16],
			(can_id[23:16] >= j1939fc_pkg::PfPdu2Min) ? can_id[15:8] : 8'h00};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= next_fields;
		end
	end

	assign out_valid = valid_s1;
	assign fields    = data_s1;

endmodule

// File: hdl/j1939fc_match.sv
// ----------------------------------------------------------------------------
// J1939 classifier rule stage
// Evaluates every classification rule in parallel into a hit vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module j1939fc_match (
	input  logic                  clk,
	input  logic                  arst_n,
	input  j1939fc_pkg::cfg_t     cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  j1939fc_pkg::fields_t  fields,
	output logic                  out_valid,
	input  logic                  out_ready,
	output j1939fc_pkg::match_t   match
);

	logic                    valid_s2;
	j1939fc_pkg::match_t     data_s2;
	j1939fc_pkg::rule_hits_t hits;
	logic to_me, to_me_or_all, in_prop_b;
	logic t6, t7, t5, t3, t0;

	// Shared qualifiers
	always_comb begin
		to_me        = (fields.da == cfg.own_address);
		to_me_or_all = to_me || (fields.da == j1939fc_pkg::DaGlobal);
		in_prop_b    = ((fields.pgn >= cfg.prop_b_low) && (fields.pgn <= cfg.prop_b_high)) ||
			((fields.pgn >= cfg.prop_b2_low) && (fields.pgn <= cfg.prop_b2_high));
		t6 = (fields.top == j1939fc_pkg::TopP6);
		t7 = (fields.top == j1939fc_pkg::TopP7);
		t5 = (fields.top == j1939fc_pkg::TopP5);
		t3 = (fields.top == j1939fc_pkg::TopP3);
		t0 = (fields.top == j1939fc_pkg::TopP0);
	end

	// One bit per rule, indexed by its class code
	always_comb begin
		hits = '0;
		hits[j1939fc_pkg::CLS_REQ]   = t6 && fields.pf == j1939fc_pkg::PfRequest && to_me_or_all;
		hits[j1939fc_pkg::CLS_DM14]  = t6 && fields.pf == j1939fc_pkg::PfDm14 && to_me;
		hits[j1939fc_pkg::CLS_ACK]   = t6 && fields.pf == j1939fc_pkg::PfAck && to_me;
		hits[j1939fc_pkg::CLS_DM15]  = t6 && fields.pf == j1939fc_pkg::PfDm15 && to_me;
		hits[j1939fc_pkg::CLS_DM16]  = t6 && fields.pf == j1939fc_pkg::PfDm16 && to_me;
		hits[j1939fc_pkg::CLS_TP_CM] = t7 && fields.pf == j1939fc_pkg::PfTpCm && to_me_or_all;
		hits[j1939fc_pkg::CLS_TP_DT] = t7 && fields.pf == j1939fc_pkg::PfTpDt && to_me_or_all;
		hits[j1939fc_pkg::CLS_PROP_A] = t5 && fields.pf == j1939fc_pkg::PfPropA &&
			fields.da == j1939fc_pkg::DaPropA;
		hits[j1939fc_pkg::CLS_PROP_B] = in_prop_b;
		hits[j1939fc_pkg::CLS_ADDR_CLAIMED] = t6 && fields.pf == j1939fc_pkg::PfAddrClaim &&
			fields.da == j1939fc_pkg::DaGlobal && fields.sa != j1939fc_pkg::SaNull;
		hits[j1939fc_pkg::CLS_ADDR_NOT_CLAIMED] = t6 &&
			fields.pf == j1939fc_pkg::PfAddrClaim && fields.da == j1939fc_pkg::DaGlobal;
		hits[j1939fc_pkg::CLS_DM1]   = t6 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da == j1939fc_pkg::DaDm1;
		hits[j1939fc_pkg::CLS_DM2]   = t6 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da == j1939fc_pkg::DaDm2;
		hits[j1939fc_pkg::CLS_SW_ID] = t6 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da == j1939fc_pkg::DaSwId;
		hits[j1939fc_pkg::CLS_ECU_ID] = t6 && fields.pf == j1939fc_pkg::PfFd &&
			fields.da == j1939fc_pkg::DaEcuId;
		hits[j1939fc_pkg::CLS_COMP_ID] = t6 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da == j1939fc_pkg::DaCompId;
		hits[j1939fc_pkg::CLS_AUX_FLOW] = t3 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da[7:4] == j1939fc_pkg::DaAuxFlow;
		hits[j1939fc_pkg::CLS_GP_FLOW] = t3 && fields.pf == j1939fc_pkg::PfGpFlow && to_me;
		hits[j1939fc_pkg::CLS_AUX_POS] = t3 && fields.pf == j1939fc_pkg::PfFf &&
			fields.da[7:4] == j1939fc_pkg::DaAuxPos;
		hits[j1939fc_pkg::CLS_AUX_CMD] = t3 && fields.pf == j1939fc_pkg::PfFe &&
			fields.da[7:4] == j1939fc_pkg::DaAuxCmd;
		hits[j1939fc_pkg::CLS_GP_CMD] = t3 && fields.pf == j1939fc_pkg::PfGpCmd && to_me;
		hits[j1939fc_pkg::CLS_ADDR_DELETE] = t0 && fields.pf == j1939fc_pkg::PfAddrDel &&
			to_me_or_all;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2.hits   <= hits;
			data_s2.da_low <= fields.da[3:0];
			data_s2.sa     <= fields.sa;
			data_s2.pgn    <= fields.pgn;
		end
	end

	assign out_valid = valid_s2;
	assign match     = data_s2;

endmodule

// File: hdl/j1939fc_prio.sv
// ----------------------------------------------------------------------------
// J1939 classifier priority stage
// Picks the first matching rule and forms the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module j1939fc_prio (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  j1939fc_pkg::match_t  match,
	output logic                 out_valid,
	input  logic                 out_ready,
	output j1939fc_pkg::result_t result
);

	logic                 valid_s3;
	j1939fc_pkg::result_t data_s3;
	j1939fc_pkg::cls_e    cls;
	logic [3:0]           valve;

	// Lowest set hit wins; no hit means unknown
	always_comb begin
		cls = j1939fc_pkg::CLS_UNKNOWN;
		for (int i = j1939fc_pkg::NumRules - 1; i >= 0; i--) begin
			if (match.hits[i]) begin
				cls = j1939fc_pkg::cls_e'(5'(i));
			end
		end
	end

	// Valve number only for the auxiliary valve classes
	always_comb begin
		if (cls inside {j1939fc_pkg::CLS_AUX_FLOW, j1939fc_pkg::CLS_AUX_POS,
				j1939fc_pkg::CLS_AUX_CMD}) begin
			valve = match.da_low;
		end else begin
			valve = 4'h0;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3.msg_class    <= cls;
			data_s3.pgn          <= match.pgn;
			data_s3.src_addr     <= match.sa;
			data_s3.valve_number <= valve;
		end
	end

	assign out_valid = valid_s3;
	assign result    = data_s3;

endmodule

// File: hdl/j1939fc_checker.sv
// ----------------------------------------------------------------------------
// J1939 classifier port checker
// Port-level checks on the classifier core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "j1939_frame_classifier_core_macros.svh"

module j1939fc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [j1939fc_pkg::OutDataWidth-1:0] m_axis_tdata
);

	// A stalled result item holds
	`J1939FC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed under stall")

	// Input backpressure only when the pipeline is full up to the output
	`J1939FC_ASSERT_IMPL(a_ready_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with output free")

	// Class code never beyond unknown
	`J1939FC_ASSERT_IMPL(a_class_range, m_axis_tvalid, m_axis_tdata[4:0] <= j1939fc_pkg::CLS_UNKNOWN, "class code out of range")

	// Valve number only on auxiliary valve classes
	`J1939FC_ASSERT_IMPL(a_valve_cls, m_axis_tvalid && m_axis_tdata[34:31] != 4'h0, m_axis_tdata[4:0] == j1939fc_pkg::CLS_AUX_FLOW || m_axis_tdata[4:0] == j1939fc_pkg::CLS_AUX_POS || m_axis_tdata[4:0] == j1939fc_pkg::CLS_AUX_CMD, "valve number on other class")

	// PDU1 formats carry a PGN with cleared low byte
	`J1939FC_ASSERT_IMPL(a_pgn_pdu1, m_axis_tvalid && m_axis_tdata[20:17] != 4'hF, m_axis_tdata[12:5] == 8'h00, "PDU1 PGN with PS kept")

endmodule

bind j1939_frame_classifier_core j1939fc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
